// File: rtl/core/round_robin_thread_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the thread scheduler
// Shared forms for the concurrent checks in the scheduler modules.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH

// Property must hold at every clock edge out of reset
`define RRTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true out of reset
`define RRTS_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and constants shared by the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int IdWidth    = 7;
    localparam int CountWidth = 32;

    typedef enum logic [2:0] {
        OP_SPAWN     = 3'd0,
        OP_TERMINATE = 3'd1,
        OP_BLOCK     = 3'd2,
        OP_RESUME    = 3'd3,
        OP_EXPIRE    = 3'd4,
        OP_LOCK      = 3'd5,
        OP_UNLOCK    = 3'd6,
        OP_READ      = 3'd7
    } op_e;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_INVALID    = 3'd1,
        STS_NO_FREE    = 3'd2,
        STS_MAIN_BLOCK = 3'd3,
        STS_OWNER      = 3'd4,
        STS_NOT_OWNER  = 3'd5,
        STS_MAIN_TERM  = 3'd6
    } status_e;

    typedef enum logic [1:0] {
        SS_ABSENT  = 2'd0,
        SS_READY   = 2'd1,
        SS_RUNNING = 2'd2,
        SS_BLOCKED = 2'd3
    } slot_state_e;

    typedef struct packed {
        slot_state_e             st;
        logic                    waits;
        logic [CountWidth-1:0]   count;
    } slot_t;

    typedef struct packed {
        op_e                  operation;
        logic [IdWidth-1:0]   thread_id;
    } evt_t;

    typedef struct packed {
        status_e                status;
        logic [IdWidth-1:0]     result_id;
        logic [IdWidth-1:0]     running_id;
        logic [CountWidth-1:0]  thread_quantums;
        logic [CountWidth-1:0]  total_quanta;
    } res_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic remove;
    } qcmd_t;

    typedef struct packed {
        logic busy;
        logic head_valid;
    } qstat_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RD_ACT, ST_RD_TID, ST_DECODE,
        ST_SP_RD, ST_SP_CHK, ST_TERM2, ST_TERM3, ST_TERM_WR,
        ST_BLK3, ST_EXP2, ST_LK2, ST_QWAIT, ST_DSP, ST_DSP_WR,
        ST_REL, ST_REL_RD, ST_REL_WR, ST_FIN, ST_FIN2
    } fsm_e;

    function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
        logic [CountWidth-1:0] r;
        r = (v == '1) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

// File: rtl/core/rrts_ram.sv
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/rrts_cell.sv
// ----------------------------------------------------------------------------
// rrts_cell
// One queue position: holds an id and moves it toward the head.
// ----------------------------------------------------------------------------
module rrts_cell #(
    parameter int IW = 7
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rrts_pkg::qcmd_t cmd,
    input  logic            init_valid,
    input  logic [IW-1:0]   push_id,
    input  logic [IW-1:0]   remove_id,
    input  logic            prev_valid,
    input  logic            next_valid,
    input  logic [IW-1:0]   next_id,
    output logic            valid,
    output logic [IW-1:0]   id
);

    logic          valid_reg, valid_next;
    logic [IW-1:0] id_reg, id_next;

    // Clear to the initial state, drop on match, take a push at the tail, shift toward a hole
    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        priority if (cmd.clear)
        begin
            valid_next = init_valid;
            id_next    = '0;
        end
        else if (cmd.remove && valid_reg && id_reg == remove_id)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.push && !valid_reg && prev_valid)
        begin
            valid_next = 1'b1;
            id_next    = push_id;
        end
        else if (!valid_reg && next_valid)
        begin
            valid_next = 1'b1;
            id_next    = next_id;
        end
        else if (valid_reg && !prev_valid)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= init_valid;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;

endmodule

// File: rtl/core/rrts_queue.sv
// ----------------------------------------------------------------------------
// rrts_queue
// FIFO of thread ids built as a chain of cells with removal from anywhere.
// ----------------------------------------------------------------------------
`include "round_robin_thread_scheduler_assert.svh"

module rrts_queue #(
    parameter int   DEPTH     = 128,
    parameter int   IW        = 7,
    parameter logic INIT_HEAD = 1'b0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rrts_pkg::qcmd_t  cmd,
    input  logic [IW-1:0]    id,
    output rrts_pkg::qstat_t stat,
    output logic [IW-1:0]    head_id
);

    localparam int BW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0] v;
    logic [IW-1:0]    ids [DEPTH];
    logic [DEPTH-1:0] acc;
    logic [BW-1:0]    busy_reg, busy_next;

    // Row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic          pv;
        logic          nv;
        logic [IW-1:0] nid;
        if (i == 0)
        begin : g_first
            assign pv = 1'b1;
        end
        else
        begin : g_rest
            assign pv = v[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign nv  = 1'b0;
            assign nid = '0;
        end
        else
        begin : g_mid
            assign nv  = v[i+1];
            assign nid = ids[i+1];
        end
        assign acc[i] = cmd.push && !v[i] && pv;
        rrts_cell #(.IW(IW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .init_valid((i == 0) ? INIT_HEAD : 1'b0),
            .push_id   (id),
            .remove_id (id),
            .prev_valid(pv),
            .next_valid(nv),
            .next_id   (nid),
            .valid     (v[i]),
            .id        (ids[i])
        );
    end

    // Hold busy while a hole travels to the tail
    always_comb
    begin
        busy_next = busy_reg;
        priority if (cmd.clear)
        begin
            busy_next = '0;
        end
        else if (cmd.remove)
        begin
            busy_next = BW'(DEPTH);
        end
        else if (busy_reg != '0)
        begin
            busy_next = busy_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign stat.busy       = (busy_reg != '0);
    assign stat.head_valid = v[0];
    assign head_id         = ids[0];

    `RRTS_ASSERT(a_push_idle, cmd.push |-> busy_reg == '0, "push while compacting")
    `RRTS_ASSERT(a_push_one, $onehot0(acc), "push taken by more than one cell")
    `RRTS_NEVER(a_push_remove, cmd.push && cmd.remove, "push and remove together")

endmodule

// File: rtl/core/round_robin_thread_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Thread scheduler with a round-robin ready queue and one mutex wait queue.
// ----------------------------------------------------------------------------
// One event is handled at a time. Slot state and quantum counts live in a
// RAM with one write and one read port, and both queues are chains of cells
// that close the gap left by a removed id one position per cycle. Each
// queue removal is waited out until that gap has closed, and spawn scans
// the slots in order, reading and then checking each one. An event also
// waits while the receiver holds off the result register. After reset, and
// after the main thread is terminated, a clearing pass rewrites every slot
// of the RAM before the next item is taken.
`include "round_robin_thread_scheduler_assert.svh"

module round_robin_thread_scheduler #(
    parameter int THREAD_SLOTS = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           evt_valid,
    output logic           evt_stall,
    input  rrts_pkg::evt_t evt,
    output logic           res_valid,
    input  logic           res_stall,
    output rrts_pkg::res_t res
);

    localparam int AW = $clog2(THREAD_SLOTS);
    localparam int IW = (AW > rrts_pkg::IdWidth) ? AW : rrts_pkg::IdWidth;
    localparam int CW = $clog2(THREAD_SLOTS + 1);
    localparam int SW = $bits(rrts_pkg::slot_t);

    rrts_pkg::fsm_e  state_reg, state_next, ret_reg, ret_next, sub_reg, sub_next;
    rrts_pkg::op_e   op_reg, op_next;
    rrts_pkg::status_e status_reg, status_next;
    logic [IW-1:0]   tid_reg, tid_next, rid_reg, rid_next;
    logic [IW-1:0]   acting_reg, acting_next, wid_reg, wid_next;
    logic [IW-1:0]   cur_reg, cur_next, owner_reg, owner_next;
    logic            locked_reg, locked_next, act_runs_reg, act_runs_next;
    logic            flag_reg, flag_next, clr_fin_reg, clr_fin_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [31:0]     total_reg, total_next;
    rrts_pkg::slot_t aent_reg, aent_next;
    logic            res_valid_reg, res_valid_next;
    rrts_pkg::res_t  res_reg, res_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    rrts_pkg::slot_t ram_wdata;
    logic [SW-1:0]   ram_rdata;
    rrts_pkg::slot_t rds;

    rrts_pkg::qcmd_t  rq_cmd, wq_cmd;
    logic [IW-1:0]    rq_id, wq_id, rq_head, wq_head;
    rrts_pkg::qstat_t rq_stat, wq_stat;

    logic tlive, act_owner, tid_owner, q_busy, spawn_hit;

    function automatic logic in_range(input logic [IW-1:0] id);
        return 32'(id) < 32'(THREAD_SLOTS);
    endfunction

    rrts_ram #(.WIDTH(SW), .DEPTH(THREAD_SLOTS)) u_slots (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    rrts_queue #(.DEPTH(THREAD_SLOTS), .IW(IW), .INIT_HEAD(1'b1)) u_ready (
        .clk(clk), .rst_n(rst_n), .cmd(rq_cmd), .id(rq_id),
        .stat(rq_stat), .head_id(rq_head)
    );

    rrts_queue #(.DEPTH(THREAD_SLOTS), .IW(IW), .INIT_HEAD(1'b0)) u_wait (
        .clk(clk), .rst_n(rst_n), .cmd(wq_cmd), .id(wq_id),
        .stat(wq_stat), .head_id(wq_head)
    );

    // Shared decode terms
    assign rds       = rrts_pkg::slot_t'(ram_rdata);
    assign tlive     = in_range(tid_reg) && rds.st != rrts_pkg::SS_ABSENT;
    assign act_owner = locked_reg && owner_reg == acting_reg;
    assign tid_owner = locked_reg && owner_reg == tid_reg;
    assign q_busy    = rq_stat.busy || wq_stat.busy;
    assign spawn_hit = rds.st == rrts_pkg::SS_ABSENT;

    // Next state and register updates
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        sub_next       = sub_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        tid_next       = tid_reg;
        rid_next       = rid_reg;
        acting_next    = acting_reg;
        wid_next       = wid_reg;
        cur_next       = cur_reg;
        owner_next     = owner_reg;
        locked_next    = locked_reg;
        act_runs_next  = act_runs_reg;
        flag_next      = flag_reg;
        clr_fin_next   = clr_fin_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        aent_next      = aent_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;

        unique case (state_reg)
            rrts_pkg::ST_CLEAR:
            begin
                if (cnt_reg == '0)
                begin
                    locked_next = 1'b0;
                    owner_next  = '0;
                    cur_next    = '0;
                    total_next  = 32'd1;
                end
                if (cnt_reg == CW'(THREAD_SLOTS - 1))
                begin
                    state_next = clr_fin_reg ? rrts_pkg::ST_FIN : rrts_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rrts_pkg::ST_IDLE:
            begin
                if (evt_valid)
                begin
                    op_next     = evt.operation;
                    tid_next    = IW'(evt.thread_id);
                    rid_next    = IW'(evt.thread_id);
                    acting_next = cur_reg;
                    status_next = rrts_pkg::STS_OK;
                    state_next  = rrts_pkg::ST_RD_ACT;
                end
            end
            rrts_pkg::ST_RD_ACT:
            begin
                state_next = rrts_pkg::ST_RD_TID;
            end
            rrts_pkg::ST_RD_TID:
            begin
                aent_next     = rds;
                act_runs_next = rds.st == rrts_pkg::SS_RUNNING;
                state_next    = rrts_pkg::ST_DECODE;
            end
            rrts_pkg::ST_DECODE:
            begin
                state_next = rrts_pkg::ST_FIN;
                unique case (op_reg)
                    rrts_pkg::OP_SPAWN:
                    begin
                        rid_next    = '0;
                        status_next = rrts_pkg::STS_NO_FREE;
                        cnt_next    = '0;
                        state_next  = rrts_pkg::ST_SP_RD;
                    end
                    rrts_pkg::OP_TERMINATE:
                    begin
                        if (!tlive)
                        begin
                            status_next = rrts_pkg::STS_INVALID;
                        end
                        else if (tid_reg == '0)
                        begin
                            status_next  = rrts_pkg::STS_MAIN_TERM;
                            cnt_next     = '0;
                            clr_fin_next = 1'b1;
                            state_next   = rrts_pkg::ST_CLEAR;
                        end
                        else
                        begin
                            flag_next = rds.st == rrts_pkg::SS_RUNNING;
                            if (tid_owner)
                            begin
                                sub_next   = rrts_pkg::ST_TERM2;
                                state_next = rrts_pkg::ST_REL;
                            end
                            else
                            begin
                                state_next = rrts_pkg::ST_TERM2;
                            end
                        end
                    end
                    rrts_pkg::OP_BLOCK:
                    begin
                        if (!tlive)
                        begin
                            status_next = rrts_pkg::STS_INVALID;
                        end
                        else if (tid_reg == '0)
                        begin
                            status_next = rrts_pkg::STS_MAIN_BLOCK;
                        end
                        else
                        begin
                            flag_next  = rds.st == rrts_pkg::SS_RUNNING;
                            ret_next   = rrts_pkg::ST_BLK3;
                            state_next = rrts_pkg::ST_QWAIT;
                        end
                    end
                    rrts_pkg::OP_RESUME:
                    begin
                        if (!tlive)
                        begin
                            status_next = rrts_pkg::STS_INVALID;
                        end
                    end
                    rrts_pkg::OP_EXPIRE:
                    begin
                        rid_next = acting_reg;
                        sub_next = rrts_pkg::ST_FIN;
                        if (act_runs_reg)
                        begin
                            ret_next   = rrts_pkg::ST_EXP2;
                            state_next = rrts_pkg::ST_QWAIT;
                        end
                        else
                        begin
                            state_next = rrts_pkg::ST_DSP;
                        end
                    end
                    rrts_pkg::OP_LOCK:
                    begin
                        rid_next = acting_reg;
                        if (act_runs_reg)
                        begin
                            if (act_owner)
                            begin
                                status_next = rrts_pkg::STS_OWNER;
                            end
                            else if (locked_reg)
                            begin
                                ret_next   = rrts_pkg::ST_LK2;
                                state_next = rrts_pkg::ST_QWAIT;
                            end
                            else
                            begin
                                locked_next = 1'b1;
                                owner_next  = acting_reg;
                            end
                        end
                    end
                    rrts_pkg::OP_UNLOCK:
                    begin
                        rid_next = acting_reg;
                        if (!act_runs_reg || !act_owner)
                        begin
                            status_next = rrts_pkg::STS_NOT_OWNER;
                        end
                        else
                        begin
                            sub_next   = rrts_pkg::ST_FIN;
                            state_next = rrts_pkg::ST_REL;
                        end
                    end
                    rrts_pkg::OP_READ:
                    begin
                        if (!tlive)
                        begin
                            status_next = rrts_pkg::STS_INVALID;
                        end
                    end
                    default:
                    begin
                        state_next = rrts_pkg::ST_FIN;
                    end
                endcase
            end
            rrts_pkg::ST_SP_RD:
            begin
                state_next = rrts_pkg::ST_SP_CHK;
            end
            rrts_pkg::ST_SP_CHK:
            begin
                if (spawn_hit)
                begin
                    rid_next    = IW'(cnt_reg);
                    status_next = rrts_pkg::STS_OK;
                    state_next  = rrts_pkg::ST_FIN;
                end
                else if (cnt_reg == CW'(THREAD_SLOTS - 1))
                begin
                    state_next = rrts_pkg::ST_FIN;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = rrts_pkg::ST_SP_RD;
                end
            end
            rrts_pkg::ST_TERM2:
            begin
                ret_next   = rrts_pkg::ST_TERM3;
                state_next = rrts_pkg::ST_QWAIT;
            end
            rrts_pkg::ST_TERM3:
            begin
                ret_next   = rrts_pkg::ST_TERM_WR;
                state_next = rrts_pkg::ST_QWAIT;
            end
            rrts_pkg::ST_TERM_WR:
            begin
                sub_next   = rrts_pkg::ST_FIN;
                state_next = flag_reg ? rrts_pkg::ST_DSP : rrts_pkg::ST_FIN;
            end
            rrts_pkg::ST_BLK3:
            begin
                sub_next   = rrts_pkg::ST_FIN;
                state_next = flag_reg ? rrts_pkg::ST_DSP : rrts_pkg::ST_FIN;
            end
            rrts_pkg::ST_EXP2:
            begin
                state_next = rrts_pkg::ST_DSP;
            end
            rrts_pkg::ST_LK2:
            begin
                sub_next   = rrts_pkg::ST_FIN;
                state_next = rrts_pkg::ST_DSP;
            end
            rrts_pkg::ST_QWAIT:
            begin
                if (!q_busy)
                begin
                    state_next = ret_reg;
                end
            end
            rrts_pkg::ST_DSP:
            begin
                if (rq_stat.head_valid && in_range(rq_head))
                begin
                    wid_next   = rq_head;
                    state_next = rrts_pkg::ST_DSP_WR;
                end
                else
                begin
                    state_next = sub_reg;
                end
            end
            rrts_pkg::ST_DSP_WR:
            begin
                cur_next   = wid_reg;
                total_next = rrts_pkg::sat_inc(total_reg);
                state_next = sub_reg;
            end
            rrts_pkg::ST_REL:
            begin
                if (!wq_stat.head_valid)
                begin
                    locked_next = 1'b0;
                    owner_next  = '0;
                    state_next  = sub_reg;
                end
                else
                begin
                    wid_next   = wq_head;
                    ret_next   = rrts_pkg::ST_REL_RD;
                    state_next = rrts_pkg::ST_QWAIT;
                end
            end
            rrts_pkg::ST_REL_RD:
            begin
                state_next = rrts_pkg::ST_REL_WR;
            end
            rrts_pkg::ST_REL_WR:
            begin
                owner_next = wid_reg;
                state_next = sub_reg;
            end
            rrts_pkg::ST_FIN:
            begin
                state_next = rrts_pkg::ST_FIN2;
            end
            rrts_pkg::ST_FIN2:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.status          = status_reg;
                    res_next.result_id       = rrts_pkg::IdWidth'(rid_reg);
                    res_next.running_id      = rrts_pkg::IdWidth'(cur_reg);
                    res_next.thread_quantums =
                        (in_range(rid_reg) && rds.st != rrts_pkg::SS_ABSENT) ? rds.count : '0;
                    res_next.total_quanta    = total_reg;
                    res_valid_next           = 1'b1;
                    state_next               = rrts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrts_pkg::ST_IDLE;
            end
        endcase
    end

    // RAM and queue commands
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        rq_cmd    = '0;
        rq_id     = '0;
        wq_cmd    = '0;
        wq_id     = '0;

        unique case (state_reg)
            rrts_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cnt_reg);
                if (cnt_reg == '0)
                begin
                    ram_wdata.st    = rrts_pkg::SS_RUNNING;
                    ram_wdata.count = 32'd1;
                    rq_cmd.clear    = 1'b1;
                    wq_cmd.clear    = 1'b1;
                end
            end
            rrts_pkg::ST_RD_ACT:
            begin
                ram_raddr = AW'(acting_reg);
            end
            rrts_pkg::ST_RD_TID:
            begin
                ram_raddr = AW'(tid_reg);
            end
            rrts_pkg::ST_DECODE:
            begin
                unique case (op_reg)
                    rrts_pkg::OP_BLOCK:
                    begin
                        if (tlive && tid_reg != '0)
                        begin
                            ram_we        = 1'b1;
                            ram_waddr     = AW'(tid_reg);
                            ram_wdata     = rds;
                            ram_wdata.st  = rrts_pkg::SS_BLOCKED;
                            rq_cmd.remove = 1'b1;
                            rq_id         = tid_reg;
                        end
                    end
                    rrts_pkg::OP_RESUME:
                    begin
                        if (tlive && rds.st == rrts_pkg::SS_BLOCKED)
                        begin
                            ram_we       = 1'b1;
                            ram_waddr    = AW'(tid_reg);
                            ram_wdata    = rds;
                            ram_wdata.st = rrts_pkg::SS_READY;
                            rq_cmd.push  = !rds.waits;
                            rq_id        = tid_reg;
                        end
                    end
                    rrts_pkg::OP_EXPIRE:
                    begin
                        if (act_runs_reg)
                        begin
                            ram_we        = 1'b1;
                            ram_waddr     = AW'(acting_reg);
                            ram_wdata     = aent_reg;
                            ram_wdata.st  = rrts_pkg::SS_READY;
                            rq_cmd.remove = 1'b1;
                            rq_id         = acting_reg;
                        end
                    end
                    rrts_pkg::OP_LOCK:
                    begin
                        if (act_runs_reg && locked_reg && !act_owner)
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = AW'(acting_reg);
                            ram_wdata       = aent_reg;
                            ram_wdata.st    = rrts_pkg::SS_READY;
                            ram_wdata.waits = 1'b1;
                            rq_cmd.remove   = 1'b1;
                            rq_id           = acting_reg;
                        end
                    end
                    default:
                    begin
                        ram_we = 1'b0;
                    end
                endcase
            end
            rrts_pkg::ST_SP_RD:
            begin
                ram_raddr = AW'(cnt_reg);
            end
            rrts_pkg::ST_SP_CHK:
            begin
                if (spawn_hit)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = AW'(cnt_reg);
                    ram_wdata.st = rrts_pkg::SS_READY;
                    rq_cmd.push  = 1'b1;
                    rq_id        = IW'(cnt_reg);
                end
            end
            rrts_pkg::ST_TERM2:
            begin
                rq_cmd.remove = 1'b1;
                rq_id         = tid_reg;
            end
            rrts_pkg::ST_TERM3:
            begin
                wq_cmd.remove = 1'b1;
                wq_id         = tid_reg;
            end
            rrts_pkg::ST_TERM_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(tid_reg);
            end
            rrts_pkg::ST_EXP2:
            begin
                rq_cmd.push = 1'b1;
                rq_id       = acting_reg;
            end
            rrts_pkg::ST_LK2:
            begin
                wq_cmd.push = !aent_reg.waits;
                wq_id       = acting_reg;
            end
            rrts_pkg::ST_DSP:
            begin
                ram_raddr = AW'(rq_head);
            end
            rrts_pkg::ST_DSP_WR:
            begin
                ram_we          = 1'b1;
                ram_waddr       = AW'(wid_reg);
                ram_wdata       = rds;
                ram_wdata.st    = rrts_pkg::SS_RUNNING;
                ram_wdata.count = rrts_pkg::sat_inc(rds.count);
            end
            rrts_pkg::ST_REL:
            begin
                if (wq_stat.head_valid)
                begin
                    wq_cmd.remove = 1'b1;
                    wq_id         = wq_head;
                end
            end
            rrts_pkg::ST_REL_RD:
            begin
                ram_raddr = AW'(wid_reg);
            end
            rrts_pkg::ST_REL_WR:
            begin
                ram_we          = 1'b1;
                ram_waddr       = AW'(wid_reg);
                ram_wdata       = rds;
                ram_wdata.waits = 1'b0;
                rq_cmd.push     = rds.st == rrts_pkg::SS_READY;
                rq_id           = wid_reg;
            end
            // Keep the result slot on the read port while the result waits
            rrts_pkg::ST_FIN, rrts_pkg::ST_FIN2:
            begin
                ram_raddr = AW'(rid_reg);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrts_pkg::ST_CLEAR;
            ret_reg       <= rrts_pkg::ST_FIN;
            sub_reg       <= rrts_pkg::ST_FIN;
            cnt_reg       <= '0;
            clr_fin_reg   <= 1'b0;
            locked_reg    <= 1'b0;
            owner_reg     <= '0;
            cur_reg       <= '0;
            total_reg     <= 32'd1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            sub_reg       <= sub_next;
            cnt_reg       <= cnt_next;
            clr_fin_reg   <= clr_fin_next;
            locked_reg    <= locked_next;
            owner_reg     <= owner_next;
            cur_reg       <= cur_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        status_reg   <= status_next;
        tid_reg      <= tid_next;
        rid_reg      <= rid_next;
        acting_reg   <= acting_next;
        wid_reg      <= wid_next;
        act_runs_reg <= act_runs_next;
        flag_reg     <= flag_next;
        aent_reg     <= aent_next;
        res_reg      <= res_next;
    end

    assign evt_stall = (state_reg != rrts_pkg::ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `RRTS_ASSERT(a_free_owner, !locked_reg |-> owner_reg == '0, "free mutex has an owner")
    `RRTS_ASSERT(a_cur_range, 32'(cur_reg) < 32'(THREAD_SLOTS), "running id out of range")
    `RRTS_NEVER(a_idle_write, state_reg == rrts_pkg::ST_IDLE && ram_we, "slot write while idle")
    `RRTS_NEVER(a_total_zero, total_reg == '0, "total quantum count wrapped")

endmodule
